>>> rtl/core/crcfr_pkg.sv
package crcfr_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  MIN_LEN     = 8'd5;
    localparam logic [7:0]  HEAD_RESET  = 8'hAA;
    localparam logic [7:0]  TAIL_RESET  = 8'h55;
    localparam logic [8:0]  LIMIT_RESET = 9'd80;
    localparam int          QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_HEAD  = 2'd0;
    localparam logic [1:0] CFG_TAIL  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_RUN,
        VERDICT_GOOD,
        VERDICT_CHECK,
        VERDICT_TAIL
    } verdict_t;

    // one queued output job; two_words also emits byte1 at position 1
    typedef struct packed {
        logic     two_words;
        logic [7:0] byte0;
        logic [7:0] pos;
        logic     eof;
        verdict_t verdict;
        logic [7:0] byte1;
    } crcfr_op_t;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> rtl/core/crcfr_front.sv
module crcfr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output logic                 push,
    output crcfr_pkg::crcfr_op_t op
);
    import crcfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic        chk_reg, chk_next;
    logic [7:0]  shead_reg, shead_next;
    logic [7:0]  head_cfg_reg;
    logic [7:0]  tail_cfg_reg;
    logic [8:0]  limit_cfg_reg;

    logic       is_head, len_ok;
    logic [8:0] pos9, len9, pos_p3, pos_p2;
    logic       is_crc, is_lo, is_hi, is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_cfg_reg  <= HEAD_RESET;
            tail_cfg_reg  <= TAIL_RESET;
            limit_cfg_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAD:  head_cfg_reg  <= cfg_data[7:0];
                CFG_TAIL:  tail_cfg_reg  <= cfg_data[7:0];
                CFG_LIMIT: limit_cfg_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign is_head = (rx_byte == head_cfg_reg);
    assign len_ok  = (rx_byte >= MIN_LEN) && ({1'b0, rx_byte} < limit_cfg_reg);
    assign pos9    = {1'b0, cnt_reg};
    assign len9    = {1'b0, len_reg};
    assign pos_p3  = pos9 + 9'd3;
    assign pos_p2  = pos9 + 9'd2;
    assign is_crc  = (pos_p3 < len9);
    assign is_lo   = (pos_p3 == len9);
    assign is_hi   = (pos_p2 == len9);
    assign is_last = !is_crc && !is_lo && !is_hi;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (len_ok)
                        phase_next = PH_BODY;
                    else if (is_head)
                        phase_next = PH_LEN;
                    else
                        phase_next = PH_HUNT;
                end
                PH_BODY:
                begin
                    if (is_last)
                        phase_next = PH_HUNT;
                end
                default:
                    phase_next = is_head ? PH_LEN : PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        chk_next   = chk_reg;
        shead_next = shead_reg;
        push       = 1'b0;
        op.two_words = 1'b0;
        op.byte0     = rx_byte;
        op.pos       = cnt_reg;
        op.eof       = 1'b0;
        op.verdict   = VERDICT_RUN;
        op.byte1     = rx_byte;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    if (len_ok)
                    begin
                        push         = 1'b1;
                        op.two_words = 1'b1;
                        op.byte0     = shead_reg;
                        op.pos       = 8'd0;
                        len_next     = rx_byte;
                        crc_next     = crc16_byte(crc_reg, rx_byte);
                        cnt_next     = 8'd2;
                    end
                    else if (is_head)
                    begin
                        shead_next = rx_byte;
                        cnt_next   = 8'd1;
                        len_next   = 8'd0;
                        crc_next   = crc16_byte(CRC_INIT, rx_byte);
                        chk_next   = 1'b1;
                    end
                    else
                    begin
                        cnt_next = 8'd0;
                        len_next = 8'd0;
                        crc_next = CRC_INIT;
                        chk_next = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    push = 1'b1;
                    if (is_crc)
                        crc_next = crc16_byte(crc_reg, rx_byte);
                    if (is_lo && (rx_byte != crc_reg[7:0]))
                        chk_next = 1'b0;
                    if (is_hi && (rx_byte != crc_reg[15:8]))
                        chk_next = 1'b0;
                    if (is_last)
                    begin
                        op.eof = 1'b1;
                        if (!chk_reg)
                            op.verdict = VERDICT_CHECK;
                        else if (rx_byte != tail_cfg_reg)
                            op.verdict = VERDICT_TAIL;
                        else
                            op.verdict = VERDICT_GOOD;
                        cnt_next = 8'd0;
                        len_next = 8'd0;
                        crc_next = CRC_INIT;
                        chk_next = 1'b1;
                    end
                    else
                        cnt_next = cnt_reg + 8'd1;
                end
                default:
                begin
                    if (is_head)
                    begin
                        shead_next = rx_byte;
                        cnt_next   = 8'd1;
                        len_next   = 8'd0;
                        crc_next   = crc16_byte(CRC_INIT, rx_byte);
                        chk_next   = 1'b1;
                    end
                    else
                    begin
                        cnt_next = 8'd0;
                        len_next = 8'd0;
                        crc_next = CRC_INIT;
                        chk_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= 8'd0;
            len_reg   <= 8'd0;
            crc_reg   <= CRC_INIT;
            chk_reg   <= 1'b1;
            shead_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            chk_reg   <= chk_next;
            shead_reg <= shead_next;
        end
    end

endmodule

>>> rtl/core/crcfr_fifo.sv
module crcfr_fifo #(
    parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  crcfr_pkg::crcfr_op_t push_op,
    input  logic                 pop,
    output crcfr_pkg::crcfr_op_t pop_op,
    output logic                 full,
    output logic                 empty
);
    import crcfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    crcfr_op_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/crcfr_back.sv
module crcfr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  crcfr_pkg::crcfr_op_t q_op,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic [7:0]           out_pos,
    output logic                 out_eof,
    output crcfr_pkg::verdict_t  out_verdict
);
    import crcfr_pkg::*;

    logic       valid_reg, valid_next;
    logic       pend_reg, pend_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] pos_reg, pos_next;
    logic       eof_reg, eof_next;
    verdict_t   verdict_reg, verdict_next;
    logic       load_ok;

    // output register is free when empty or being drained this cycle
    assign load_ok = !valid_reg || out_ready;
    assign q_pop   = load_ok && !pend_reg && !q_empty;

    always_comb
    begin
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        byte_next      = byte_reg;
        pos_next       = pos_reg;
        eof_next       = eof_reg;
        verdict_next   = verdict_reg;
        if (load_ok)
        begin
            if (pend_reg)
            begin
                // length byte that followed the head
                valid_next   = 1'b1;
                pend_next    = 1'b0;
                byte_next    = pend_byte_reg;
                pos_next     = 8'd1;
                eof_next     = 1'b0;
                verdict_next = VERDICT_RUN;
            end
            else if (!q_empty)
            begin
                valid_next     = 1'b1;
                pend_next      = q_op.two_words;
                pend_byte_next = q_op.byte1;
                byte_next      = q_op.byte0;
                pos_next       = q_op.pos;
                eof_next       = q_op.eof;
                verdict_next   = q_op.verdict;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        byte_reg      <= byte_next;
        pos_reg       <= pos_next;
        eof_reg       <= eof_next;
        verdict_reg   <= verdict_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_pos     = pos_reg;
    assign out_eof     = eof_reg;
    assign out_verdict = verdict_reg;

endmodule

>>> rtl/core/crc16_frame_receiver_top.sv
// Length-prefixed frame receiver with CRC-16/MODBUS check.
// Slave stream (s_*): one received byte per word. Master stream (m_*): one
// word per echoed byte of an accepted frame: byte, position in the frame,
// tlast on the last byte and the verdict in tuser (0 running, 1 good,
// 2 check mismatch, 3 tail mismatch).
// Config port: cfg_we writes cfg_data to register cfg_index (0 head byte,
// 1 tail byte, 2 length limit); write only while the block is idle.
// Throughput: one input word per cycle while the queue has room. The parser
// updates the CRC as each byte is accepted and posts output jobs to a
// QUEUE_DEPTH-entry queue; the output stage drains one job per cycle while
// m_tready allows, the job that carries the head and length bytes together
// leaving as two words. A result word passes through the queue and the
// output register before it is valid on m_*, later if older jobs are queued.
// Head and length bytes leave as consecutive words once the length is accepted.
// Reset: hunting for the head, registers at 0xAA / 0x55 / 80, queue and
// output register empty.
// When the master side stalls, the queue fills and s_tready drops once it
// is full; no word is lost or repeated.
module crc16_frame_receiver_top #(
    parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] byte_position
    output logic        m_tlast,   // end_of_frame
    output logic [1:0]  m_tuser    // [1:0] verdict
);
    import crcfr_pkg::*;

    logic      accept;
    logic      fr_push;
    crcfr_op_t fr_op;
    crcfr_op_t q_op;
    logic      q_full, q_empty, q_pop;
    logic [7:0] out_byte, out_pos;
    verdict_t  out_verdict;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    crcfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .push      (fr_push),
        .op        (fr_op)
    );

    crcfr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fr_push),
        .push_op (fr_op),
        .pop     (q_pop),
        .pop_op  (q_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    crcfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_op        (q_op),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_pos     (out_pos),
        .out_eof     (m_tlast),
        .out_verdict (out_verdict)
    );

    assign m_tdata = {out_pos, out_byte};
    assign m_tuser = out_verdict;

    // a job is only ever posted when the queue has room
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fr_push |-> !q_full)
        else $error("job posted to a full queue");

    // verdict is reported exactly on the last byte
    a_verdict_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != VERDICT_RUN)))
        else $error("verdict and end of frame disagree");

    // the head byte never closes a frame
    a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:8] == 8'd0)) |-> !m_tlast)
        else $error("frame ends at position zero");

    // a job posted into an empty pipe is queued at the accepting edge and
    // loaded into the output register at the following one
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (fr_push && q_empty && !m_tvalid) |=> ##1 m_tvalid)
        else $error("output word missing after job posted");

endmodule
